FILE: hw/rtl/fav_pkg.sv
// Package for the frustum box visibility test: sizes, plane and box types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fav_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int REG_COUNT   = 8;
  localparam int MAT_IDX_W   = $clog2(REG_COUNT);
  localparam int CFG_IDX_W   = MAT_IDX_W + 1;
  localparam int CFG_DATA_W  = 64;
  localparam int COORD_W     = 32;
  localparam int PLANE_W     = COORD_W + 1;
  localparam int PROD_W      = PLANE_W + COORD_W;
  localparam int FRAC_W      = 16;
  localparam int DSH_W       = PLANE_W + FRAC_W;
  localparam int PAIR_W      = PROD_W + 1;
  localparam int DIST_W      = PROD_W + 2;
  localparam int PIPE_DEPTH  = 4;
  localparam int ROW_W       = 4 * COORD_W;

  typedef struct packed {
    logic signed [PLANE_W-1:0] nx;
    logic signed [PLANE_W-1:0] ny;
    logic signed [PLANE_W-1:0] nz;
    logic signed [PLANE_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

endpackage
`default_nettype wire

FILE: hw/rtl/frustum_aabb_visibility_test.sv
// Top level of the frustum box visibility test: config port, box input
// register, six plane pipelines and the result register.
// Depends on fav_pkg, fav_cfg_regs, fav_plane_eval.
//
// Usage:
//   Load the view-projection matrix through the cfg_ channel (index 0..7,
//   row r columns 2h/2h+1 at index 2r+h, low column in the low half).
//   Writes to other indexes are dropped. Plane values are registered from
//   the matrix registers after a write; write only while no box is in flight.
//   A box request is taken on a clock edge with start high and busy low.
//   busy is high only in reset, so a box may enter every cycle.
//   Pipeline: out_valid is high for one cycle per box, and out_visible is
//   valid in that cycle; the box is registered at the request edge,
//   then four stages follow (select and multiply, pair sums, final sum
//   and sign, OR of six planes).
//   Throughput is one box per cycle while busy is low; every stage is fully pipelined.
//   The receiver cannot stall; results are never held.
//   Reset clears the matrix to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module frustum_aabb_visibility_test (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [fav_pkg::COORD_W-1:0] in_min_x,
  input  wire logic signed [fav_pkg::COORD_W-1:0] in_min_y,
  input  wire logic signed [fav_pkg::COORD_W-1:0] in_min_z,
  input  wire logic signed [fav_pkg::COORD_W-1:0] in_max_x,
  input  wire logic signed [fav_pkg::COORD_W-1:0] in_max_y,
  input  wire logic signed [fav_pkg::COORD_W-1:0] in_max_z,
  output logic                               out_valid,
  output logic                               out_visible,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fav_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fav_pkg::*;

  logic                     busy_r;
  logic                     accept;
  logic [PIPE_DEPTH-1:0]    vld_r;
  logic                     out_valid_r;
  logic                     visible_r;
  box_t                     box_r;
  plane_t [PLANE_COUNT-1:0] planes;
  logic [PLANE_COUNT-1:0]   culled;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  fav_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .planes   (planes)
  );

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fav_plane_eval u_eval (
      .clk    (clk),
      .plane  (planes[p]),
      .box    (box_r),
      .culled (culled[p])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], accept};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    box_r.min_x <= in_min_x;
    box_r.min_y <= in_min_y;
    box_r.min_z <= in_min_z;
    box_r.max_x <= in_max_x;
    box_r.max_y <= in_max_y;
    box_r.max_z <= in_max_z;
    visible_r   <= !(|culled);
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

`ifndef ASSERT_OFF
  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("request did not produce a result after five cycles");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  a_reset_empties: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (!out_valid && (vld_r == '0)))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/fav_cfg_regs.sv
// Matrix register bank and registered clip plane derivation.
// Depends on fav_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fav_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [fav_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire logic [fav_pkg::CFG_DATA_W-1:0]     wr_data,
  output fav_pkg::plane_t [fav_pkg::PLANE_COUNT-1:0] planes
);
  import fav_pkg::*;

  logic [CFG_DATA_W-1:0] mat_r [REG_COUNT];
  plane_t [PLANE_COUNT-1:0] planes_r, planes_nxt;

  // rows packed as {c3, c2, c1, c0}
  logic [ROW_W-1:0] row_w [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_w[2'(r)] = {mat_r[MAT_IDX_W'(2 * r + 1)], mat_r[MAT_IDX_W'(2 * r)]};
    end
  end

  always_comb begin
    logic signed [PLANE_W-1:0] a;
    logic signed [PLANE_W-1:0] b;
    logic signed [PLANE_W-1:0] v [4];
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int j = 0; j < 4; j++) begin
        a = PLANE_W'($signed(row_w[3][COORD_W*j +: COORD_W]));
        b = PLANE_W'($signed(row_w[2'(p >> 1)][COORD_W*j +: COORD_W]));
        v[j] = ((p & 1) != 0) ? a - b : a + b;
      end
      planes_nxt[p].nx = v[0];
      planes_nxt[p].ny = v[1];
      planes_nxt[p].nz = v[2];
      planes_nxt[p].d  = v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        mat_r[i] <= '0;
      end
    end else if (wr_en && (wr_index < CFG_IDX_W'(REG_COUNT))) begin
      mat_r[wr_index[MAT_IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    planes_r <= planes_nxt;
  end

  assign planes = planes_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fav_plane_eval.sv
// Three-stage signed distance test of one box against one plane:
// p-vertex select and multiply, pair sums, final sum and sign.
// Depends on fav_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fav_plane_eval (
  input  wire logic            clk,
  input  wire fav_pkg::plane_t plane,
  input  wire fav_pkg::box_t   box,
  output logic                 culled
);
  import fav_pkg::*;

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r, prod_z_r;
  logic signed [DSH_W-1:0]   dsh_r;
  logic signed [PAIR_W-1:0]  sum_xy_r, sum_zd_r;
  logic signed [DIST_W-1:0]  dist_sum;
  logic                      culled_r;

  // p-vertex: max corner where the normal component is non-negative
  always_comb begin
    px = plane.nx[PLANE_W-1] ? box.min_x : box.max_x;
    py = plane.ny[PLANE_W-1] ? box.min_y : box.max_y;
    pz = plane.nz[PLANE_W-1] ? box.min_z : box.max_z;
  end

  assign dist_sum = DIST_W'(sum_xy_r) + DIST_W'(sum_zd_r);

  always_ff @(posedge clk) begin
    prod_x_r <= PROD_W'(plane.nx) * PROD_W'(px);
    prod_y_r <= PROD_W'(plane.ny) * PROD_W'(py);
    prod_z_r <= PROD_W'(plane.nz) * PROD_W'(pz);
    dsh_r    <= {plane.d, FRAC_W'(0)};
    sum_xy_r <= PAIR_W'(prod_x_r) + PAIR_W'(prod_y_r);
    sum_zd_r <= PAIR_W'(prod_z_r) + PAIR_W'(dsh_r);
    culled_r <= dist_sum[DIST_W-1];
  end

  assign culled = culled_r;

endmodule
`default_nettype wire
